>>> src/sdtq_pkg.sv
`default_nettype none

package sdtq_pkg;

    // Number of alarm slots in the cell chain.
    localparam int DEPTH = 16;
    // Most expired alarms reported for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int EXP_CNT_W = $clog2(MAX_RESULTS + 1);

    localparam int TICK_W = 32;
    localparam int DELAY_W = 16;
    localparam int TAG_W = 16;

    typedef enum logic
    {
        CMD_INSERT = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_EXPIRED  = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } cell_op_t;

    typedef enum logic
    {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    typedef struct packed
    {
        logic               valid;
        logic [TICK_W-1:0]  deadline;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed
    {
        cell_op_t           op;
        logic [TICK_W-1:0]  deadline;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } cell_ctrl_t;

    // True when deadline a is equal to or later than deadline b, wrap-aware.
    function automatic logic at_or_after(input logic [TICK_W-1:0] a,
                                         input logic [TICK_W-1:0] b);
        logic [TICK_W-1:0] diff;
        diff = a - b;
        return ~diff[TICK_W-1];
    endfunction

    // True when the deadline has been reached or passed at time now.
    function automatic logic has_passed(input logic [TICK_W-1:0] deadline,
                                        input logic [TICK_W-1:0] now);
        logic [TICK_W-1:0] diff;
        diff = deadline - now;
        return (diff == '0) || diff[TICK_W-1];
    endfunction

endpackage

`default_nettype wire

>>> src/sdtq_cell.sv
`default_nettype none

// One slot of the sorted chain. On an insert the slot keeps its entry, takes
// the new alarm, or takes its left neighbor's entry, depending on whether the
// insert point lies to its right, here, or to its left. On a pop it takes its
// right neighbor's entry.
module sdtq_cell
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire sdtq_pkg::cell_ctrl_t ctrl,
    input  wire sdtq_pkg::entry_t     left_entry,
    input  wire sdtq_pkg::entry_t     right_entry,
    input  wire                       found_in,
    output logic                      found_out,
    output sdtq_pkg::entry_t          entry
);

    sdtq_pkg::entry_t entry_reg;
    sdtq_pkg::entry_t entry_next;
    logic             goes_here;

    // The new alarm belongs at the first free slot or ahead of the first
    // entry whose deadline is equal or later.
    assign goes_here = !entry_reg.valid
                       || sdtq_pkg::at_or_after(entry_reg.deadline, ctrl.deadline);
    assign found_out = found_in || goes_here;
    assign entry     = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            sdtq_pkg::CELL_INSERT:
            begin
                if (found_in)
                begin
                    entry_next = left_entry;
                end
                else if (goes_here)
                begin
                    entry_next.valid    = 1'b1;
                    entry_next.deadline = ctrl.deadline;
                    entry_next.delay    = ctrl.delay;
                    entry_next.tag      = ctrl.tag;
                end
            end
            sdtq_pkg::CELL_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

`default_nettype wire

>>> src/sorted_deadline_timer_queue.sv
`default_nettype none

// Sorted deadline timer queue. Holds up to sdtq_pkg::DEPTH pending alarms in
// a chain of cells kept in deadline order, the earliest at the head. An insert
// transfer (s_tuser = 0) stores the alarm with deadline = tick count + delay
// ahead of the first alarm whose deadline is equal or later, so equal
// deadlines leave newest first, and answers with one result: kind 0 when
// stored, kind 1 when the queue is full (the queue is then unchanged). A tick
// transfer (s_tuser = 1) advances the 32-bit tick count, which wraps, and then
// reports every alarm at the head whose deadline has been reached, oldest
// deadline first, as kind 2 results carrying the alarm's delay and tag, with
// m_tlast on the final one; at most sdtq_pkg::MAX_RESULTS are reported per
// tick and any others stay queued for the next tick. A tick that expires
// nothing gives no result. Deadline comparisons are wrap-aware (difference
// taken modulo 2^32). On an insert every cell decides its own move in
// parallel. A tick first advances the count and then pops the head cell once
// per cycle while the output register is free, the whole chain shifting by
// one on each pop, until the head holds no alarm left to report. The result
// sits in an output register, so a stalled m_tready holds the block only
// while that register is occupied. After reset the queue is empty and the
// tick count is zero.
module sorted_deadline_timer_queue
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,  // [15:0] delay_seconds, [31:16] tag
    input  wire  [0:0]  s_tuser,  // [0] cmd
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,  // [15:0] delay_seconds_out, [31:16] tag_out
    output logic [1:0]  m_tuser,  // [1:0] kind
    output logic        m_tlast   // last
);

    localparam logic [sdtq_pkg::DEPTH-1:0] VEC_ONE = {{(sdtq_pkg::DEPTH-1){1'b0}}, 1'b1};

    // Input payload.
    logic [sdtq_pkg::DELAY_W-1:0] in_delay;
    logic [sdtq_pkg::TAG_W-1:0]   in_tag;
    sdtq_pkg::cmd_t               in_cmd;

    assign in_delay = s_tdata[15:0];
    assign in_tag   = s_tdata[31:16];
    assign in_cmd   = sdtq_pkg::cmd_t'(s_tuser[0]);

    // Control state.
    sdtq_pkg::state_t                state_reg, state_next;
    logic [sdtq_pkg::TICK_W-1:0]     tick_reg, tick_next;
    logic [sdtq_pkg::EXP_CNT_W-1:0]  exp_cnt_reg, exp_cnt_next;

    // Output register.
    logic                         m_tvalid_reg, m_tvalid_next;
    sdtq_pkg::kind_t              out_kind_reg, out_kind_next;
    logic [sdtq_pkg::DELAY_W-1:0] out_delay_reg, out_delay_next;
    logic [sdtq_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic                         out_last_reg, out_last_next;

    // Cell chain.
    sdtq_pkg::cell_ctrl_t  cell_ctrl;
    sdtq_pkg::entry_t      cell_entry [sdtq_pkg::DEPTH];
    logic [sdtq_pkg::DEPTH:0]   found_chain;
    logic [sdtq_pkg::DEPTH-1:0] valid_vec;

    // Decoded conditions.
    logic out_free;
    logic accept;
    logic queue_full;
    logic head_expired;
    logic next_expired;
    logic load_out;
    logic [sdtq_pkg::EXP_CNT_W-1:0] exp_cnt_inc;

    assign out_free    = !m_tvalid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign queue_full  = cell_entry[sdtq_pkg::DEPTH-1].valid;
    assign exp_cnt_inc = exp_cnt_reg + 1'b1;

    assign head_expired = cell_entry[0].valid
                          && sdtq_pkg::has_passed(cell_entry[0].deadline, tick_reg)
                          && (exp_cnt_reg < sdtq_pkg::EXP_CNT_W'(sdtq_pkg::MAX_RESULTS));
    assign next_expired = cell_entry[1].valid
                          && sdtq_pkg::has_passed(cell_entry[1].deadline, tick_reg)
                          && (exp_cnt_inc < sdtq_pkg::EXP_CNT_W'(sdtq_pkg::MAX_RESULTS));

    // The chain: each cell sees its neighbors and passes the insert-point
    // flag to the right.
    assign found_chain[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < sdtq_pkg::DEPTH; gi++)
        begin : g_cell
            sdtq_pkg::entry_t left_e;
            sdtq_pkg::entry_t right_e;

            if (gi == 0)
            begin : g_first
                assign left_e = '0;
            end
            else
            begin : g_mid_l
                assign left_e = cell_entry[gi-1];
            end

            if (gi == sdtq_pkg::DEPTH - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_mid_r
                assign right_e = cell_entry[gi+1];
            end

            sdtq_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .left_entry  (left_e),
                .right_entry (right_e),
                .found_in    (found_chain[gi]),
                .found_out   (found_chain[gi+1]),
                .entry       (cell_entry[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdtq_pkg::ST_IDLE:
            begin
                if (accept && (in_cmd == sdtq_pkg::CMD_TICK))
                begin
                    state_next = sdtq_pkg::ST_DRAIN;
                end
            end
            sdtq_pkg::ST_DRAIN:
            begin
                if (!head_expired)
                begin
                    state_next = sdtq_pkg::ST_IDLE;
                end
                else if (out_free && !next_expired)
                begin
                    state_next = sdtq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdtq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: handshake, chain command, result load.
    always_comb
    begin
        s_tready           = 1'b0;
        load_out           = 1'b0;
        cell_ctrl.op       = sdtq_pkg::CELL_HOLD;
        cell_ctrl.deadline = tick_reg + {{(sdtq_pkg::TICK_W-sdtq_pkg::DELAY_W){1'b0}}, in_delay};
        cell_ctrl.delay    = in_delay;
        cell_ctrl.tag      = in_tag;
        out_kind_next      = out_kind_reg;
        out_delay_next     = out_delay_reg;
        out_tag_next       = out_tag_reg;
        out_last_next      = out_last_reg;
        tick_next          = tick_reg;
        exp_cnt_next       = exp_cnt_reg;
        unique case (state_reg)
            sdtq_pkg::ST_IDLE:
            begin
                s_tready = out_free;
                if (accept)
                begin
                    if (in_cmd == sdtq_pkg::CMD_INSERT)
                    begin
                        load_out       = 1'b1;
                        out_delay_next = in_delay;
                        out_tag_next   = in_tag;
                        out_last_next  = 1'b1;
                        if (queue_full)
                        begin
                            out_kind_next = sdtq_pkg::KIND_REJECTED;
                        end
                        else
                        begin
                            out_kind_next = sdtq_pkg::KIND_ACCEPTED;
                            cell_ctrl.op  = sdtq_pkg::CELL_INSERT;
                        end
                    end
                    else
                    begin
                        tick_next    = tick_reg + 1'b1;
                        exp_cnt_next = '0;
                    end
                end
            end
            sdtq_pkg::ST_DRAIN:
            begin
                if (head_expired && out_free)
                begin
                    load_out       = 1'b1;
                    cell_ctrl.op   = sdtq_pkg::CELL_POP;
                    out_kind_next  = sdtq_pkg::KIND_EXPIRED;
                    out_delay_next = cell_entry[0].delay;
                    out_tag_next   = cell_entry[0].tag;
                    out_last_next  = !next_expired;
                    exp_cnt_next   = exp_cnt_inc;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sdtq_pkg::ST_IDLE;
            tick_reg     <= '0;
            exp_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            exp_cnt_reg  <= exp_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_delay_reg <= out_delay_next;
        out_tag_reg   <= out_tag_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_tag_reg, out_delay_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // The stored alarms always fill the chain from the head without gaps.
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec & (valid_vec + VEC_ONE)) == '0)
        else $error("cell chain holds a gap");

    // A stored insert adds exactly one alarm to the chain.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.op == sdtq_pkg::CELL_INSERT)
        |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
        else $error("insert did not add one alarm");

    // Only a stored alarm is ever popped from the head.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctrl.op == sdtq_pkg::CELL_POP) |-> cell_entry[0].valid)
        else $error("pop from an empty chain");

    // Never more expired results for one tick than allowed.
    a_exp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        exp_cnt_reg <= sdtq_pkg::EXP_CNT_W'(sdtq_pkg::MAX_RESULTS))
        else $error("too many expired results for one tick");

endmodule

`default_nettype wire
